[design/tgadec_pkg.sv]
// ----------------------------------------------------------------------------
// tgadec_pkg
// Shared types and constants for the TGA 24-bit RLE decoder.
// ----------------------------------------------------------------------------
package tgadec_pkg;

  localparam int MAX_DIM = 1024;
  localparam int DIM_W   = 11;   // image width / height as reported
  localparam int POS_W   = 10;   // row / column of a pixel
  localparam int AREA_W  = 21;   // pixel count of the largest image

  // image types
  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;

  // pixel depths
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // status codes
  localparam logic [2:0] ST_PIXELS     = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd2;
  localparam logic [2:0] ST_CMAP_DEPTH = 3'd3;
  localparam logic [2:0] ST_DEPTH_32   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [POS_W-1:0] dest_row;
    logic [POS_W-1:0] dest_column;
    logic [7:0]       run_length;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             image_done;
    logic [2:0]       status;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  // steps of the row/column divide
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MID,
    DIV_LAST
  } div_step_t;

endpackage

[design/tgadec_out_buf.sv]
// ----------------------------------------------------------------------------
// tgadec_out_buf
// Result register with a skid stage, so the parser keeps taking bytes while
// a finished item waits downstream.
// ----------------------------------------------------------------------------
module tgadec_out_buf import tgadec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  result_t   res,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // no new item can arrive while the skid stage is occupied
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_r || take) begin
        out_data_nxt  = res.item;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res.item;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/tga_rle_rgb24_decoder_core.sv]
// ----------------------------------------------------------------------------
// tga_rle_rgb24_decoder_core
// TGA type 2 / type 10 24-bit decoder: one file byte in, at most one pixel,
// run descriptor or status report out.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the skid stage of the result buffer is
// empty; the result of a byte is registered in the result buffer.
// The row/column advance after a run is a restoring divide by the image width in
// steps (top bits with the result item, DIV_MID, DIV_LAST), at most three quotient
// bits a cycle; results are at least three bytes apart, so it ends before the next one.
// Reset (rst_n low, synchronous) returns the parser to header byte 0 and
// empties the result register; first_byte does the same for the parser.
module tga_rle_rgb24_decoder_core import tgadec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [4:0] HB_ID_LEN  = 5'd0;
  localparam logic [4:0] HB_CMAP    = 5'd1;
  localparam logic [4:0] HB_TYPE    = 5'd2;
  localparam logic [4:0] HB_W_LO    = 5'd12;
  localparam logic [4:0] HB_W_HI    = 5'd13;
  localparam logic [4:0] HB_H_LO    = 5'd14;
  localparam logic [4:0] HB_H_HI    = 5'd15;
  localparam logic [4:0] HB_DEPTH   = 5'd16;
  localparam logic [4:0] HB_ATTR    = 5'd17;

  logic accept;
  logic [7:0] b;

  // parser control state
  phase_t            phase_r, phase_nxt, ph_c;
  logic [4:0]        hidx_r, hidx_nxt, hidx_c;
  logic [7:0]        idskip_r, idskip_nxt;
  logic [7:0]        pkt_left_r, pkt_left_nxt, pkt_c;
  logic              pkt_run_r, pkt_run_nxt, pkt_run_c;
  logic [1:0]        comp_r, comp_nxt, comp_c;
  logic [DIM_W-1:0]  row_r, row_nxt, row_c;
  logic [DIM_W-1:0]  col_r, col_nxt, col_c;

  // header fields and pixel bookkeeping
  logic [7:0]        id_len_r, cmap_r, type_r, depth_r, attr_r;
  logic [15:0]       w_r, h_r;
  logic [7:0]        held_b_r, held_b_nxt, held_g_r, held_g_nxt;
  logic [AREA_W-1:0] remain_r, remain_nxt;
  logic [2*DIM_W-1:0] area;

  logic [2:0]        status_c;
  logic              is_rle;
  logic [7:0]        run_n, n_clip;
  logic              done;
  result_t           res;

  // width divide for the row/column advance
  div_step_t         div_step_r, div_step_nxt;
  logic [11:0]       div_rem_r, div_rem_nxt;
  logic [7:0]        div_quot_r, div_quot_nxt;
  logic              div_start;
  logic [18:0]       div_w, rem_a, rem_m, rem_l;
  logic [7:0]        quot_a, quot_m, quot_l;

  assign accept = in_valid && !in_stall;
  assign b      = in_data.data_byte;

  // first_byte restarts parsing on this very byte
  assign ph_c      = in_data.first_byte ? PH_HEADER : phase_r;
  assign hidx_c    = in_data.first_byte ? 5'd0 : hidx_r;
  assign pkt_c     = in_data.first_byte ? 8'd0 : pkt_left_r;
  assign pkt_run_c = in_data.first_byte ? 1'b0 : pkt_run_r;
  assign comp_c    = in_data.first_byte ? 2'd0 : comp_r;
  assign row_c     = in_data.first_byte ? '0 : row_r;
  assign col_c     = in_data.first_byte ? '0 : col_r;

  assign is_rle = (type_r == TYPE_RLE);
  assign area   = w_r[DIM_W-1:0] * h_r[DIM_W-1:0];

  always_comb begin
    if (w_r > 16'(MAX_DIM) || h_r > 16'(MAX_DIM)) begin
      status_c = ST_TOO_LARGE;
    end else if (!(type_r inside {TYPE_RAW, TYPE_RLE})) begin
      status_c = ST_BAD_TYPE;
    end else if (cmap_r != 8'd0 || !(depth_r inside {DEPTH_24, DEPTH_32})) begin
      status_c = ST_CMAP_DEPTH;
    end else if (depth_r != DEPTH_24) begin
      status_c = ST_DEPTH_32;
    end else begin
      status_c = ST_PIXELS;
    end
  end

  assign run_n = (is_rle && pkt_run_c) ? pkt_c : 8'd1;

  always_comb begin
    div_w  = {8'b0, w_r[DIM_W-1:0]};
    // top quotient bits, taken with the result item
    rem_a  = {7'b0, {1'b0, col_c} + {4'b0, run_n}};
    quot_a = '0;
    for (int k = 7; k >= 5; k--) begin
      if (rem_a >= (div_w << k)) begin
        rem_a     = rem_a - (div_w << k);
        quot_a[k] = 1'b1;
      end
    end
    rem_m  = {7'b0, div_rem_r};
    quot_m = div_quot_r;
    for (int k = 4; k >= 2; k--) begin
      if (rem_m >= (div_w << k)) begin
        rem_m     = rem_m - (div_w << k);
        quot_m[k] = 1'b1;
      end
    end
    rem_l  = {7'b0, div_rem_r};
    quot_l = div_quot_r;
    for (int k = 1; k >= 0; k--) begin
      if (rem_l >= (div_w << k)) begin
        rem_l     = rem_l - (div_w << k);
        quot_l[k] = 1'b1;
      end
    end
  end

  always_comb begin
    phase_nxt    = ph_c;
    hidx_nxt     = hidx_c;
    idskip_nxt   = idskip_r;
    pkt_left_nxt = pkt_c;
    pkt_run_nxt  = pkt_run_c;
    comp_nxt     = comp_c;
    held_b_nxt   = held_b_r;
    held_g_nxt   = held_g_r;
    remain_nxt   = remain_r;
    n_clip       = run_n;
    done         = 1'b0;
    div_start    = 1'b0;
    res          = '0;
    res.item.image_width  = w_r[DIM_W-1:0];
    res.item.image_height = h_r[DIM_W-1:0];

    case (ph_c)
      PH_HEADER: begin
        hidx_nxt = hidx_c + 5'd1;
        if (hidx_c == HB_ATTR) begin
          if (status_c != ST_PIXELS) begin
            phase_nxt       = PH_IDLE;
            res.valid       = 1'b1;
            res.item.status = status_c;
          end else if (w_r == 16'd0 || h_r == 16'd0) begin
            phase_nxt = PH_IDLE;
          end else begin
            idskip_nxt = id_len_r;
            phase_nxt  = (id_len_r != 8'd0) ? PH_IDSKIP : PH_PIXELS;
            remain_nxt = area[AREA_W-1:0];
          end
        end
      end
      PH_IDSKIP: begin
        idskip_nxt = idskip_r - 8'd1;
        if (idskip_r == 8'd1) begin
          phase_nxt = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (is_rle && pkt_c == 8'd0) begin
          // packet header byte
          pkt_left_nxt = 8'd1 + {1'b0, b[6:0]};
          pkt_run_nxt  = b[7];
          comp_nxt     = 2'd0;
        end else if (comp_c < 2'd2) begin
          if (comp_c[0]) begin
            held_g_nxt = b;
          end else begin
            held_b_nxt = b;
          end
          comp_nxt = comp_c + 2'd1;
        end else begin
          comp_nxt = 2'd0;
          if (is_rle) begin
            pkt_left_nxt = pkt_run_c ? 8'd0 : pkt_c - 8'd1;
          end
          // clip at the end of the image
          if ({13'b0, run_n} > remain_r) begin
            n_clip = remain_r[7:0];
          end
          done = ({13'b0, n_clip} == remain_r);
          res.valid            = 1'b1;
          res.item.red         = b;
          res.item.green       = held_g_r;
          res.item.blue        = held_b_r;
          res.item.dest_row    = attr_r[5] ? row_c[POS_W-1:0]
                                           : h_r[POS_W-1:0] - 10'd1 - row_c[POS_W-1:0];
          res.item.dest_column = col_c[POS_W-1:0];
          res.item.run_length  = n_clip;
          res.item.image_done  = done;
          res.item.status      = ST_PIXELS;
          remain_nxt = remain_r - {13'b0, n_clip};
          div_start  = 1'b1;
          if (done) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    if (!accept) begin
      res.valid = 1'b0;
      div_start = 1'b0;
    end
  end

  always_comb begin
    div_step_nxt = div_step_r;
    div_rem_nxt  = div_rem_r;
    div_quot_nxt = div_quot_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    case (div_step_r)
      DIV_MID: begin
        div_rem_nxt  = rem_m[11:0];
        div_quot_nxt = quot_m;
        div_step_nxt = DIV_LAST;
      end
      DIV_LAST: begin
        row_nxt      = row_r + {3'b0, quot_l};
        col_nxt      = rem_l[DIM_W-1:0];
        div_step_nxt = DIV_IDLE;
      end
      default: begin
      end
    endcase
    if (accept && in_data.first_byte) begin
      row_nxt      = '0;
      col_nxt      = '0;
      div_step_nxt = DIV_IDLE;
    end
    if (div_start) begin
      div_rem_nxt  = rem_a[11:0];
      div_quot_nxt = quot_a;
      div_step_nxt = DIV_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hidx_r     <= '0;
      idskip_r   <= '0;
      pkt_left_r <= '0;
      pkt_run_r  <= 1'b0;
      comp_r     <= '0;
      row_r      <= '0;
      col_r      <= '0;
      div_step_r <= DIV_IDLE;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        hidx_r     <= hidx_nxt;
        idskip_r   <= idskip_nxt;
        pkt_left_r <= pkt_left_nxt;
        pkt_run_r  <= pkt_run_nxt;
        comp_r     <= comp_nxt;
      end
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      div_step_r <= div_step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_rem_r  <= div_rem_nxt;
    div_quot_r <= div_quot_nxt;
    if (accept) begin
      held_b_r <= held_b_nxt;
      held_g_r <= held_g_nxt;
      remain_r <= remain_nxt;
      if (ph_c == PH_HEADER) begin
        case (hidx_c)
          HB_ID_LEN: id_len_r   <= b;
          HB_CMAP:   cmap_r     <= b;
          HB_TYPE:   type_r     <= b;
          HB_W_LO:   w_r[7:0]   <= b;
          HB_W_HI:   w_r[15:8]  <= b;
          HB_H_LO:   h_r[7:0]   <= b;
          HB_H_HI:   h_r[15:8]  <= b;
          HB_DEPTH:  depth_r    <= b;
          HB_ATTR:   attr_r     <= b;
          default: begin
          end
        endcase
      end
    end
  end

  tgadec_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[dv/tga_rle_rgb24_decoder_core_tb.sv]
// ----------------------------------------------------------------------------
// tga_rle_rgb24_decoder_core_tb
// Streams TGA files byte by byte into the decoder and checks every pixel or
// run descriptor against a cycle-free model of the parser. A short table of
// header bytes comes first, then random raw, run-length and broken files,
// with random gaps on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tga_rle_rgb24_decoder_core_tb;
  import tgadec_pkg::*;

  localparam int          N_ITEMS       = 850;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_CYCLES  = 20;
  localparam logic [7:0]  RUN_FLAG      = 8'h80;
  localparam logic [7:0]  COUNT_MASK    = 8'h7f;
  localparam logic [7:0]  ATTR_TOP_DOWN = 8'h20;
  localparam int          DIR_CHECK_ROW = 17;

  // header bytes after reset with no first_byte: rle, 1024 x 1025, too large
  localparam logic [7:0] DIR_BYTES [22] = '{
    8'hff, 8'h00, TYPE_RLE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'h00, 8'h04, 8'h01, 8'h04, DEPTH_24, ATTR_TOP_DOWN,
    8'h00, 8'hff, 8'h80, 8'h7f
  };

  typedef struct {
    bit        typed;
    out_item_t exp;
  } plan_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // decoder model state
  logic [7:0]  hdr_mem [16];
  int unsigned hdr_pos;
  int unsigned skip_left;
  int unsigned pkt_left;
  bit          pkt_is_run;
  int unsigned comp_pos;
  logic [15:0] bg_hold;
  int unsigned cur_row;
  int unsigned cur_col;
  phase_t      dec_phase;

  out_item_t   decoded_q [$];
  plan_t       plan_q [$];
  logic [7:0]  file_q [$];
  int          fail_cnt   = 0;
  int          items_sent = 0;
  int          cycle_cnt  = 0;
  bit          calm       = 1'b0;
  bit          want_hold  = 1'b0;
  bit          hold_done  = 1'b0;

  tga_rle_rgb24_decoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void decoder_reset();
    foreach (hdr_mem[i]) hdr_mem[i] = '0;
    hdr_pos    = 0;
    skip_left  = 0;
    pkt_left   = 0;
    pkt_is_run = 1'b0;
    comp_pos   = 0;
    bg_hold    = '0;
    cur_row    = 0;
    cur_col    = 0;
    dec_phase  = PH_HEADER;
  endfunction

  function automatic bit decode_byte(input in_item_t it, output out_item_t res);
    int unsigned idx, slot, w, h, pos, remain, n, drow;
    logic [2:0]  st;
    logic [7:0]  b;
    bit          rle;
    bit          done;
    b   = it.data_byte;
    res = '0;
    if (it.first_byte) decoder_reset();
    if (dec_phase == PH_HEADER) begin
      idx  = hdr_pos;
      // depth and attribute bytes land in the unused colormap slots
      slot = (idx == 16) ? 3 : (idx == 17) ? 4 : idx;
      hdr_mem[slot[3:0]] = b;
      hdr_pos = (idx + 1) & 31;
      if (idx < 17) return 1'b0;
    end
    w = {hdr_mem[13], hdr_mem[12]};
    h = {hdr_mem[15], hdr_mem[14]};
    res.image_width  = w[DIM_W-1:0];
    res.image_height = h[DIM_W-1:0];
    case (dec_phase)
      PH_HEADER: begin
        st = ST_PIXELS;
        if (w > MAX_DIM || h > MAX_DIM) st = ST_TOO_LARGE;
        else if (hdr_mem[2] != TYPE_RAW && hdr_mem[2] != TYPE_RLE) st = ST_BAD_TYPE;
        else if (hdr_mem[1] != 0 || (hdr_mem[3] != DEPTH_32 && hdr_mem[3] != DEPTH_24))
          st = ST_CMAP_DEPTH;
        else if (hdr_mem[3] != DEPTH_24) st = ST_DEPTH_32;
        if (st != ST_PIXELS) begin
          dec_phase  = PH_IDLE;
          res.status = st;
          return 1'b1;
        end
        if (w == 0 || h == 0) begin
          dec_phase = PH_IDLE;
          return 1'b0;
        end
        skip_left = hdr_mem[0];
        dec_phase = (skip_left != 0) ? PH_IDSKIP : PH_PIXELS;
        return 1'b0;
      end
      PH_IDSKIP: begin
        skip_left = (skip_left - 1) & 255;
        if (skip_left == 0) dec_phase = PH_PIXELS;
        return 1'b0;
      end
      PH_PIXELS: begin
        rle = hdr_mem[2] == TYPE_RLE;
        if (rle && pkt_left == 0) begin
          pkt_left   = 1 + (b & COUNT_MASK);
          pkt_is_run = (b & RUN_FLAG) != 0;
          comp_pos   = 0;
          return 1'b0;
        end
        if (comp_pos < 2) begin
          if (comp_pos == 0) bg_hold[7:0] = b;
          else bg_hold[15:8] = b;
          comp_pos++;
          return 1'b0;
        end
        comp_pos = 0;
        pos    = cur_row * w + cur_col;
        remain = w * h - pos;
        n      = 1;
        if (rle) begin
          if (pkt_is_run) begin
            n        = pkt_left;
            pkt_left = 0;
          end else begin
            pkt_left--;
          end
        end
        if (n > remain) n = remain;
        drow = ((hdr_mem[4] & ATTR_TOP_DOWN) != 0) ? cur_row : h - 1 - cur_row;
        done = n == remain;
        res.red         = b;
        res.green       = bg_hold[15:8];
        res.blue        = bg_hold[7:0];
        res.dest_row    = drow[POS_W-1:0];
        res.dest_column = cur_col[POS_W-1:0];
        res.run_length  = n[7:0];
        res.image_done  = done;
        res.status      = ST_PIXELS;
        pos     = pos + n;
        cur_row = (pos / w) & 32'h7ff;
        cur_col = (pos % w) & 32'h7ff;
        if (done) dec_phase = PH_IDLE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_result(input out_item_t exp, input out_item_t act);
    if (act.red !== exp.red) begin
      $error("red: expected %0d, got %0d", exp.red, act.red);
      fail_cnt++;
    end
    if (act.green !== exp.green) begin
      $error("green: expected %0d, got %0d", exp.green, act.green);
      fail_cnt++;
    end
    if (act.blue !== exp.blue) begin
      $error("blue: expected %0d, got %0d", exp.blue, act.blue);
      fail_cnt++;
    end
    if (act.dest_row !== exp.dest_row) begin
      $error("dest_row: expected %0d, got %0d", exp.dest_row, act.dest_row);
      fail_cnt++;
    end
    if (act.dest_column !== exp.dest_column) begin
      $error("dest_column: expected %0d, got %0d", exp.dest_column, act.dest_column);
      fail_cnt++;
    end
    if (act.run_length !== exp.run_length) begin
      $error("run_length: expected %0d, got %0d", exp.run_length, act.run_length);
      fail_cnt++;
    end
    if (act.image_width !== exp.image_width) begin
      $error("image_width: expected %0d, got %0d", exp.image_width, act.image_width);
      fail_cnt++;
    end
    if (act.image_height !== exp.image_height) begin
      $error("image_height: expected %0d, got %0d", exp.image_height, act.image_height);
      fail_cnt++;
    end
    if (act.image_done !== exp.image_done) begin
      $error("image_done: expected %0d, got %0d", exp.image_done, act.image_done);
      fail_cnt++;
    end
    if (act.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, act.status);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t pred;
    bit        has;
    plan_t     pl;
    if (!rst_n) begin
      decoder_reset();
    end else begin
      if (in_valid && !in_stall) begin
        has = decode_byte(in_data, pred);
        if (plan_q.size() != 0) begin
          pl = plan_q.pop_front();
          if (pl.typed) begin
            has  = 1'b1;
            pred = pl.exp;
          end
        end
        if (has) decoded_q.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result with nothing expected: red %0d status %0d",
                 out_data.red, out_data.status);
          fail_cnt++;
        end else begin
          check_result(decoded_q.pop_front(), out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off while the sender keeps going
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 9);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic first);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, first_byte: first};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic make_file(input bit forced);
    int unsigned w, h, id_len, npix, cnt, len, pk, mode;
    logic [7:0]  typ, cmap, depth, attr;
    bit          run, ok, big;
    file_q.delete();
    mode   = $urandom_range(99);
    id_len = ($urandom_range(5) == 0) ? $urandom_range(1, 5) : 0;
    if ($urandom_range(59) == 0) id_len = 255;
    typ   = $urandom_range(1) ? TYPE_RLE : TYPE_RAW;
    cmap  = '0;
    depth = DEPTH_24;
    attr  = 8'($urandom_range(255));
    w     = $urandom_range(1, 4);
    h     = $urandom_range(1, 3);
    if (forced) begin
      id_len = 0;
      typ    = TYPE_RAW;
      w      = 8;
      h      = 4;
    end else if (mode < 4) begin
      w   = MAX_DIM;
      h   = $urandom_range(1, 2);
      typ = TYPE_RLE;
    end else if (mode < 7) begin
      w   = $urandom_range(1, 2);
      h   = MAX_DIM;
      typ = TYPE_RLE;
    end else if (mode < 9) begin
      // largest image, cut short by the next file
      w   = MAX_DIM;
      h   = MAX_DIM;
      typ = TYPE_RLE;
    end else if (mode < 12) w = $urandom_range(MAX_DIM + 1, 65535);
    else if (mode < 15) h = $urandom_range(MAX_DIM + 1, 65535);
    else if (mode < 18) typ = 8'($urandom_range(255));
    else if (mode < 21) cmap = 8'($urandom_range(1, 255));
    else if (mode < 24) depth = 8'($urandom_range(255));
    else if (mode < 27) depth = DEPTH_32;
    else if (mode < 31) begin
      if ($urandom_range(1)) w = 0;
      else h = 0;
    end

    file_q.push_back(id_len[7:0]);
    file_q.push_back(cmap);
    file_q.push_back(typ);
    repeat (9) file_q.push_back(8'($urandom_range(255)));
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(h[15:8]);
    file_q.push_back(depth);
    file_q.push_back(attr);

    ok = w <= MAX_DIM && h <= MAX_DIM && (typ == TYPE_RAW || typ == TYPE_RLE) &&
         cmap == 0 && depth == DEPTH_24 && w != 0 && h != 0;
    if (!ok) begin
      repeat ($urandom_range(2)) file_q.push_back(8'($urandom_range(255)));
      return;
    end
    repeat (id_len) file_q.push_back(8'($urandom_range(255)));
    npix = w * h;
    if (typ == TYPE_RAW) begin
      if (npix > 40) npix = $urandom_range(1, 40);
      repeat (3 * npix) file_q.push_back(8'($urandom_range(255)));
    end else begin
      big = npix > 64;
      cnt = 0;
      pk  = 0;
      // the last packet may run past the image end and get clipped
      while (cnt < npix && pk < 24) begin
        run = big ? ($urandom_range(7) != 0) : $urandom_range(1);
        if (big || $urandom_range(7) == 0) len = $urandom_range(96, 127);
        else len = $urandom_range(0, 3);
        if (!run && len > 7) len = ($urandom_range(39) == 0) ? 127 : $urandom_range(0, 7);
        file_q.push_back({run, len[6:0]});
        repeat (run ? 3 : 3 * (len + 1)) file_q.push_back(8'($urandom_range(255)));
        cnt += len + 1;
        pk++;
      end
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(255)));
    if (!forced && $urandom_range(9) == 0)
      repeat ($urandom_range(1, 5)) if (file_q.size() > 18) void'(file_q.pop_back());
  endtask

  initial begin
    bit    forced;
    bit    hold_given;
    plan_t pl;
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    hold_given = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < 22; i++) begin
      pl.typed = i == DIR_CHECK_ROW;
      pl.exp   = '{default: '0, image_width: 11'd1024, image_height: 11'd1025,
                   status: ST_TOO_LARGE};
      plan_q.push_back(pl);
      send_item(DIR_BYTES[i], 1'b0);
    end

    while (items_sent < N_ITEMS) begin
      forced = !hold_given && items_sent >= 300;
      if (forced) hold_given = 1'b1;
      make_file(forced);
      foreach (file_q[i]) begin
        calm = items_sent >= 550 && items_sent < 700;
        send_item(file_q[i], i == 0);
        // receiver holds off once the pixel bytes start
        if (forced && i == 17) want_hold = 1'b1;
      end
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
design/tgadec_pkg.sv
design/tgadec_out_buf.sv
design/tga_rle_rgb24_decoder_core.sv
dv/tga_rle_rgb24_decoder_core_tb.sv
